// ===== hw/rtl/sfr_pkg.sv =====
// Shared constants, types and helpers for the SPI flash responder.
package sfr_pkg;

	localparam int DEF_MEM_DEPTH = 65536;
	localparam logic [31:0] ID_WORD_RESET = 32'hCA7C_A7FF;

	localparam logic [7:0] OP_READ      = 8'h03;
	localparam logic [7:0] OP_QUAD_READ = 8'hEB;
	localparam logic [7:0] OP_READ_ID   = 8'h9F;
	localparam logic [7:0] OP_WAKE      = 8'hAB;
	localparam logic [7:0] OP_RESET_EN  = 8'hFF;
	localparam logic [7:0] OP_RD_SR2    = 8'h35;
	localparam logic [7:0] OP_WR_SR2    = 8'h31;
	localparam logic [7:0] OP_VOL_SR_EN = 8'h50;
	localparam logic [7:0] OP_RD_SR1    = 8'h05;
	localparam logic [7:0] OP_WR_SR1    = 8'h01;
	localparam logic [7:0] OP_WR_EN     = 8'h06;

	localparam logic [2:0] READ_DATA_PHASE      = 3'd3;
	localparam logic [2:0] QUAD_READ_DATA_PHASE = 3'd6;
	localparam logic [2:0] PHASE_MAX            = 3'd7;
	localparam logic [3:0] BYTE_BITS            = 4'd8;

	typedef enum logic [1:0] {
		STAT_OK          = 2'd0,
		STAT_UNKNOWN_CMD = 2'd1,
		STAT_BEYOND_MEM  = 2'd2
	} status_t;

	function automatic logic known_command(input logic [7:0] c);
		logic k;
		k = 1'b0;
		case (c)
			OP_WAKE, OP_READ, OP_READ_ID, OP_RESET_EN, OP_RD_SR2, OP_WR_SR2,
			OP_VOL_SR_EN, OP_RD_SR1, OP_WR_SR1, OP_WR_EN, OP_QUAD_READ: k = 1'b1;
			default: k = 1'b0;
		endcase
		return k;
	endfunction

endpackage

// ===== hw/rtl/spi_flash_responder_core.sv =====
// SPI NOR flash responder: pin sampling, command decode and memory read-out.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | input     | in_valid / in_stall   | mode clk_pin select_n data_in_pins
//          |           |                       | load_address load_byte
//  out     | output    | out_valid / out_stall | drive_pins status
//  cfg     | input     | cfg_valid / cfg_ready | cfg_data (id_word)
//
// One transaction per cycle unless stalled; each result is registered for the next cycle.
// A memory byte read on a completed byte is picked up from the memory read register
// by the next pin sample; one memory read per transaction keeps the rate at one per cycle.
// in_stall is high only while a result waits in the output register and out_stall is high.
// Reset clears all pin state; the memory has no reset and is defined by loads alone.
module spi_flash_responder_core #(
	parameter int MEM_DEPTH = sfr_pkg::DEF_MEM_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic        clk_pin,
	input  logic        select_n,
	input  logic [3:0]  data_in_pins,
	input  logic [15:0] load_address,
	input  logic [7:0]  load_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  drive_pins,
	output logic [1:0]  status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam logic [24:0] DEPTH_W = 25'(MEM_DEPTH);

	logic [7:0] mem [MEM_DEPTH];
	logic [7:0] rd_data_q;

	logic [31:0] id_word_q;
	logic        prev_clk_q;
	logic        prev_sel_q;
	logic [3:0]  bit_cnt_q;
	logic [2:0]  phase_q;
	logic [1:0]  id_idx_q;
	logic [7:0]  opcode_q;
	logic [23:0] addr_q;
	logic        quad_q;
	logic [7:0]  shift_in_q;
	logic [7:0]  shift_out_q;
	logic        pend_q;
	logic [3:0]  drive_hold_q;
	logic        out_valid_q;
	sfr_pkg::status_t status_q;

	logic        in_fire;
	logic        pin_item;
	logic        desel, rise, fall;
	logic [7:0]  so_cur;
	logic [7:0]  si_n;
	logic [7:0]  so_n;
	logic [3:0]  bc_sum;
	logic        fin;
	logic [7:0]  op_n;
	logic [23:0] addr_or;
	logic [23:0] addr_n;
	logic        rd_en;
	logic        rd_in_range;
	logic        quad_n;
	logic [3:0]  bc_n;
	logic [2:0]  phase_n;
	logic [1:0]  id_idx_n;
	logic [3:0]  drive_n;
	logic        pend_n;
	logic [7:0]  id_byte;
	logic [23:0] ld_ext;
	logic        mem_we;
	sfr_pkg::status_t stat_n;

	assign in_stall  = out_valid_q & out_stall;
	assign in_fire   = in_valid & ~in_stall;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign drive_pins = drive_hold_q;
	assign status    = status_q;

	assign pin_item = ~mode;
	assign desel    = select_n & ~prev_sel_q;
	assign rise     = ~desel & clk_pin & ~prev_clk_q & ~select_n;
	assign fall     = ~desel & ~clk_pin & prev_clk_q & ~select_n;
	assign so_cur   = pend_q ? rd_data_q : shift_out_q;
	assign bc_sum   = bit_cnt_q + (quad_q ? 4'd4 : 4'd1);
	assign fin      = rise & (bc_sum >= sfr_pkg::BYTE_BITS);
	assign si_n     = quad_q ? {shift_in_q[3:0], data_in_pins}
	                         : {shift_in_q[6:0], data_in_pins[0]};
	assign op_n     = (phase_q == 3'd0) ? si_n : opcode_q;
	assign rd_in_range = {1'b0, addr_or} < DEPTH_W;
	assign ld_ext   = {8'd0, load_address};
	assign mem_we   = in_fire & mode & ({1'b0, ld_ext} < DEPTH_W);

	always_comb begin
		case (id_idx_q)
			2'd0:    id_byte = id_word_q[31:24];
			2'd1:    id_byte = id_word_q[23:16];
			2'd2:    id_byte = id_word_q[15:8];
			default: id_byte = id_word_q[7:0];
		endcase
	end

	always_comb begin
		addr_or = addr_q;
		rd_en   = 1'b0;
		stat_n  = sfr_pkg::STAT_OK;
		quad_n  = quad_q;
		if (phase_q == 3'd0) begin
			addr_or = '0;
			quad_n  = (si_n == sfr_pkg::OP_QUAD_READ);
			if (!sfr_pkg::known_command(si_n))
				stat_n = sfr_pkg::STAT_UNKNOWN_CMD;
		end else if (opcode_q == sfr_pkg::OP_READ || opcode_q == sfr_pkg::OP_QUAD_READ) begin
			case (phase_q)
				3'd1:    addr_or = {si_n, addr_q[15:0]};
				3'd2:    addr_or = {addr_q[23:16], si_n, addr_q[7:0]};
				3'd3:    addr_or = {addr_q[23:8], si_n};
				default: addr_or = addr_q;
			endcase
			if (phase_q >= ((opcode_q == sfr_pkg::OP_READ) ? sfr_pkg::READ_DATA_PHASE
			                                               : sfr_pkg::QUAD_READ_DATA_PHASE)) begin
				rd_en = 1'b1;
				if (!rd_in_range)
					stat_n = sfr_pkg::STAT_BEYOND_MEM;
			end
		end
		addr_n = rd_en ? addr_or + 24'd1 : addr_or;
	end

	always_comb begin
		so_n     = so_cur;
		pend_n   = 1'b0;
		bc_n     = bit_cnt_q;
		phase_n  = phase_q;
		id_idx_n = id_idx_q;
		drive_n  = drive_hold_q;
		if (desel) begin
			bc_n     = '0;
			phase_n  = '0;
			id_idx_n = '0;
		end else if (rise) begin
			so_n = quad_q ? {so_cur[3:0], 4'd0} : {so_cur[6:0], 1'b0};
			bc_n = bc_sum;
			if (fin) begin
				so_n = '0;
				if (rd_en && rd_in_range)
					pend_n = 1'b1;
				if (op_n == sfr_pkg::OP_READ_ID)
					so_n = id_byte;
				if (phase_q != sfr_pkg::PHASE_MAX)
					phase_n = phase_q + 3'd1;
				id_idx_n = id_idx_q + 2'd1;
				bc_n     = '0;
			end
		end else if (fall) begin
			drive_n = quad_q ? so_cur[7:4] : {2'b00, so_cur[7], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[ld_ext[ADDR_W-1:0]] <= load_byte;
		if (in_fire && pin_item && fin && rd_en && rd_in_range)
			rd_data_q <= mem[addr_or[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_word_q <= sfr_pkg::ID_WORD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			id_word_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_clk_q   <= 1'b0;
			prev_sel_q   <= 1'b1;
			bit_cnt_q    <= '0;
			phase_q      <= '0;
			id_idx_q     <= '0;
			opcode_q     <= '0;
			addr_q       <= '0;
			quad_q       <= 1'b0;
			shift_in_q   <= '0;
			shift_out_q  <= '0;
			pend_q       <= 1'b0;
			drive_hold_q <= '0;
			out_valid_q  <= 1'b0;
			status_q     <= sfr_pkg::STAT_OK;
		end else begin
			if (!in_stall)
				out_valid_q <= in_valid;
			if (in_fire) begin
				status_q <= sfr_pkg::STAT_OK;
				if (pin_item) begin
					prev_clk_q   <= clk_pin;
					prev_sel_q   <= select_n;
					bit_cnt_q    <= bc_n;
					phase_q      <= phase_n;
					id_idx_q     <= id_idx_n;
					shift_out_q  <= so_n;
					pend_q       <= pend_n;
					drive_hold_q <= drive_n;
					if (desel)
						quad_q <= 1'b0;
					if (rise)
						shift_in_q <= si_n;
					if (fin) begin
						opcode_q <= op_n;
						addr_q   <= addr_n;
						quad_q   <= quad_n;
						status_q <= stat_n;
					end
				end
			end
		end
	end

	a_bit_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q < sfr_pkg::BYTE_BITS)
		else $error("bit counter out of range");

	a_quad_nibble: assert property (@(posedge clk) disable iff (!arst_n)
		quad_q |-> (bit_cnt_q == 4'd0 || bit_cnt_q == 4'd4))
		else $error("quad mode off nibble boundary");

	a_pend_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(pend_q) |-> $past(in_fire) && !$past(mode))
		else $error("memory read pending without a pin transaction");

	a_status_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$changed(status_q) |-> out_valid_q)
		else $error("status changed without a result");

endmodule

// ===== sim/spi_flash_responder_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for spi_flash_responder_core: SPI pin-level stimulus against a predictor.
module spi_flash_responder_core_test;

	localparam int FLASH_BYTES = sfr_pkg::DEF_MEM_DEPTH;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic        mode;
		logic        clk_pin;
		logic        select_n;
		logic [3:0]  pins;
		logic [15:0] ld_addr;
		logic [7:0]  ld_byte;
	} pin_item_t;

	typedef struct packed {
		logic [3:0]       drive;
		sfr_pkg::status_t stat;
	} flash_reply_t;

	typedef struct packed {
		logic        prev_clk;
		logic        prev_sel_n;
		logic [3:0]  bit_cnt;
		logic [2:0]  phase;
		logic [1:0]  id_idx;
		logic [7:0]  opcode;
		logic [23:0] addr;
		logic        quad;
		logic [7:0]  sh_in;
		logic [7:0]  sh_out;
		logic [3:0]  drive;
	} pin_state_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        mode;
	logic        clk_pin;
	logic        select_n;
	logic [3:0]  data_in_pins;
	logic [15:0] load_address;
	logic [7:0]  load_byte;
	logic        out_valid;
	logic        out_stall;
	logic [3:0]  drive_pins;
	logic [1:0]  status;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	pin_state_t   flash_state;
	logic [7:0]   flash_image [int];
	logic [31:0]  id_word_shadow;
	flash_reply_t reply_q [$];

	int send_idle_pct = 15;
	int recv_idle_pct = 50;
	int stall_hold_cycles = 0;
	int items_sent = 0;
	int loads_sent = 0;
	int phase_items = 0;
	int id_writes = 0;
	int replies_checked = 0;
	int unknown_seen = 0;
	int beyond_seen = 0;
	int mismatches = 0;

	spi_flash_responder_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.clk_pin      (clk_pin),
		.select_n     (select_n),
		.data_in_pins (data_in_pins),
		.load_address (load_address),
		.load_byte    (load_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.drive_pins   (drive_pins),
		.status       (status),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("spi_flash_responder_core test failed");
		$finish;
	end

	function automatic void flash_predict(inout pin_state_t s, input pin_item_t it,
			output flash_reply_t r, output logic mem_rd, output logic [23:0] mem_addr);
		int byte_sh;
		r.stat = sfr_pkg::STAT_OK;
		mem_rd = 1'b0;
		mem_addr = '0;
		if (it.mode) begin
			if (int'(it.ld_addr) < FLASH_BYTES)
				flash_image[int'(it.ld_addr)] = it.ld_byte;
		end else begin
			if (it.select_n && !s.prev_sel_n) begin
				s.bit_cnt = '0;
				s.phase = '0;
				s.id_idx = '0;
				s.quad = 1'b0;
			end else if (it.clk_pin && !s.prev_clk && !it.select_n) begin
				if (s.quad) begin
					s.sh_in = {s.sh_in[3:0], it.pins};
					s.sh_out = {s.sh_out[3:0], 4'h0};
					s.bit_cnt = s.bit_cnt + 4'd4;
				end else begin
					s.sh_in = {s.sh_in[6:0], it.pins[0]};
					s.sh_out = {s.sh_out[6:0], 1'b0};
					s.bit_cnt = s.bit_cnt + 4'd1;
				end
				if (s.bit_cnt >= sfr_pkg::BYTE_BITS) begin
					s.sh_out = '0;
					if (s.phase == 3'd0) begin
						s.addr = '0;
						s.quad = 1'b0;
						s.opcode = s.sh_in;
						if (s.opcode == sfr_pkg::OP_QUAD_READ)
							s.quad = 1'b1;
						else if (!(s.opcode inside {sfr_pkg::OP_WAKE, sfr_pkg::OP_READ,
								sfr_pkg::OP_READ_ID, sfr_pkg::OP_RESET_EN,
								sfr_pkg::OP_RD_SR2, sfr_pkg::OP_WR_SR2,
								sfr_pkg::OP_VOL_SR_EN, sfr_pkg::OP_RD_SR1,
								sfr_pkg::OP_WR_SR1, sfr_pkg::OP_WR_EN}))
							r.stat = sfr_pkg::STAT_UNKNOWN_CMD;
					end else if (s.opcode == sfr_pkg::OP_READ
							|| s.opcode == sfr_pkg::OP_QUAD_READ) begin
						if (s.phase <= 3'd3) begin
							byte_sh = (3 - int'(s.phase)) * 8;
							s.addr = s.addr | (24'(s.sh_in) << byte_sh);
						end
						if (s.phase >= (s.opcode == sfr_pkg::OP_READ
								? sfr_pkg::READ_DATA_PHASE
								: sfr_pkg::QUAD_READ_DATA_PHASE)) begin
							if (int'(s.addr) < FLASH_BYTES) begin
								mem_rd = 1'b1;
								mem_addr = s.addr;
								s.sh_out = flash_image.exists(int'(s.addr))
									? flash_image[int'(s.addr)] : 8'h00;
							end else
								r.stat = sfr_pkg::STAT_BEYOND_MEM;
							s.addr = s.addr + 24'd1;
						end
					end
					if (s.opcode == sfr_pkg::OP_READ_ID)
						s.sh_out = id_word_shadow[8 * (3 - int'(s.id_idx)) +: 8];
					if (s.phase < sfr_pkg::PHASE_MAX)
						s.phase = s.phase + 3'd1;
					s.id_idx = s.id_idx + 2'd1;
					s.bit_cnt = '0;
				end
			end else if (!it.clk_pin && s.prev_clk && !it.select_n) begin
				s.drive = s.quad ? s.sh_out[7:4] : {2'b00, s.sh_out[7], 1'b0};
			end
			s.prev_clk = it.clk_pin;
			s.prev_sel_n = it.select_n;
		end
		r.drive = s.drive;
	endfunction

	task automatic send_item(input pin_item_t it);
		flash_reply_t r;
		logic rd;
		logic [23:0] rd_addr;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.mode;
		clk_pin <= it.clk_pin;
		select_n <= it.select_n;
		data_in_pins <= it.pins;
		load_address <= it.ld_addr;
		load_byte <= it.ld_byte;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		flash_predict(flash_state, it, r, rd, rd_addr);
		reply_q.push_back(r);
		items_sent++;
		phase_items++;
		if (it.mode)
			loads_sent++;
		@(negedge clk);
	endtask

	task automatic mem_load(input logic [15:0] a, input logic [7:0] v);
		pin_item_t it;
		it.mode = 1'b1;
		it.clk_pin = 1'($urandom);
		it.select_n = 1'($urandom);
		it.pins = 4'($urandom);
		it.ld_addr = a;
		it.ld_byte = v;
		send_item(it);
	endtask

	task automatic pin_sample(input logic c, input logic sel_n, input logic [3:0] d);
		pin_item_t it;
		pin_state_t probe;
		flash_reply_t r;
		logic rd;
		logic [23:0] rd_addr;
		it.mode = 1'b0;
		it.clk_pin = c;
		it.select_n = sel_n;
		it.pins = d;
		it.ld_addr = 16'($urandom);
		it.ld_byte = 8'($urandom);
		probe = flash_state;
		flash_predict(probe, it, r, rd, rd_addr);
		// fill any byte this sample would fetch before it has been loaded
		if (rd && !flash_image.exists(int'(rd_addr)))
			mem_load(rd_addr[15:0], 8'($urandom));
		send_item(it);
	endtask

	task automatic host_byte(input logic [7:0] b, input logic quad, input int edges);
		logic [3:0] d;
		for (int i = 0; i < (quad ? 2 : 8) && i < edges; i++) begin
			d = quad ? (i == 0 ? b[7:4] : b[3:0]) : {3'($urandom), b[7 - i]};
			pin_sample(1'b0, 1'b0, d);
			if ($urandom_range(7) == 0)
				pin_sample(1'b0, 1'b0, d);
			pin_sample(1'b1, 1'b0, d);
		end
	endtask

	task automatic spi_frame(input logic [7:0] op, input logic [23:0] addr, input int n_data,
			input int tail_edges);
		logic quad;
		pin_sample(1'b0, 1'b1, 4'($urandom));
		pin_sample(1'b0, 1'b0, 4'($urandom));
		host_byte(op, 1'b0, 8);
		quad = (op == sfr_pkg::OP_QUAD_READ);
		if (op == sfr_pkg::OP_READ || quad)
			for (int k = 2; k >= 0; k--)
				host_byte(addr[8 * k +: 8], quad, 8);
		if (quad)
			repeat (2) host_byte(8'($urandom), 1'b1, 8);
		repeat (n_data) host_byte(8'($urandom), quad, 8);
		if (tail_edges > 0)
			host_byte(8'($urandom), quad, tail_edges);
		pin_sample(1'b0, 1'b0, 4'($urandom));
		pin_sample(1'b0, 1'b1, 4'($urandom));
	endtask

	task automatic write_id(input logic [31:0] v);
		in_valid <= 1'b0;
		while (reply_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		id_word_shadow = v;
		id_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_frame(input logic broken);
		logic [7:0] op;
		logic [23:0] addr;
		int pick;
		pick = $urandom_range(99);
		if (pick < 35)
			op = sfr_pkg::OP_READ;
		else if (pick < 70)
			op = sfr_pkg::OP_QUAD_READ;
		else if (pick < 85)
			op = sfr_pkg::OP_READ_ID;
		else if (pick < 95)
			op = sfr_pkg::OP_WR_EN;
		else
			op = 8'($urandom);
		case ($urandom_range(9))
			0, 1, 2, 3, 4, 5: addr = 24'($urandom_range(255));
			6, 7:             addr = 24'(FLASH_BYTES - 4 + $urandom_range(7));
			8:                addr = 24'($urandom);
			default:          addr = 24'hFFFFFC + 24'($urandom_range(3));
		endcase
		if (broken)
			spi_frame(op, addr, $urandom_range(1), $urandom_range(1, 7));
		else
			spi_frame(op, addr, $urandom_range(1), 0);
	endtask

	task automatic random_mix(input int quota);
		int pick;
		phase_items = 0;
		while (phase_items < quota) begin
			pick = $urandom_range(99);
			if (pick < 60)
				random_frame(1'b0);
			else if (pick < 72)
				random_frame(1'b1);
			else if (pick < 86)
				repeat ($urandom_range(4, 12))
					pin_sample(1'($urandom), $urandom_range(3) == 0, 4'($urandom));
			else
				repeat ($urandom_range(1, 4))
					mem_load($urandom_range(1) ? 16'($urandom_range(255)) : 16'($urandom),
						8'($urandom));
		end
	endtask

	task automatic test_idle_pins();
		mem_load(16'h0000, 8'h00);
		mem_load(16'hFFFF, 8'hFF);
		pin_sample(1'b1, 1'b1, 4'hF);
		pin_sample(1'b0, 1'b1, 4'h0);
		pin_sample(1'b1, 1'b1, 4'h0);
		pin_sample(1'b0, 1'b1, 4'hF);
	endtask

	task automatic test_accepted_commands();
		logic [7:0] ops [8];
		ops = '{sfr_pkg::OP_WAKE, sfr_pkg::OP_RESET_EN, sfr_pkg::OP_RD_SR2,
			sfr_pkg::OP_WR_SR2, sfr_pkg::OP_VOL_SR_EN, sfr_pkg::OP_RD_SR1,
			sfr_pkg::OP_WR_SR1, sfr_pkg::OP_WR_EN};
		spi_frame(ops[$urandom_range(7)], '0, 0, 2);
	endtask

	task automatic test_unknown_command();
		spi_frame(8'h5A, '0, 0, 1);
	endtask

	task automatic test_read_id();
		spi_frame(sfr_pkg::OP_READ_ID, '0, 2, 0);
		write_id($urandom);
		spi_frame(sfr_pkg::OP_READ_ID, '0, 0, 3);
	endtask

	task automatic test_single_read();
		spi_frame(sfr_pkg::OP_READ, 24'h000100, 0, 3);
	endtask

	task automatic test_quad_read();
		spi_frame(sfr_pkg::OP_QUAD_READ, 24'(FLASH_BYTES - 1), 2, 0);
	endtask

	task automatic test_memory_edges();
		spi_frame(sfr_pkg::OP_QUAD_READ, 24'hFFFFFF, 2, 0);
	endtask

	task automatic test_deselect();
		pin_sample(1'b0, 1'b1, 4'h0);
		pin_sample(1'b0, 1'b0, 4'h0);
		host_byte(sfr_pkg::OP_READ, 1'b0, 8);
		host_byte(8'h00, 1'b0, 5);
		pin_sample(1'b0, 1'b0, 4'h0);
		// deselect wins over a clock rise in the same sample
		pin_sample(1'b1, 1'b1, 4'hF);
		pin_sample(1'b0, 1'b1, 4'hF);
		// select fall and clock rise together still shift the first bit
		pin_sample(1'b1, 1'b0, 4'h1);
		host_byte(8'h3E, 1'b0, 7);
		host_byte(8'($urandom), 1'b0, 8);
		pin_sample(1'b0, 1'b0, 4'h0);
		pin_sample(1'b0, 1'b1, 4'h0);
	endtask

	task automatic test_random_traffic(input int s_pct, input int r_pct, input int quota);
		write_id($urandom);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		random_mix(quota);
	endtask

	task automatic test_stall_pressure();
		stall_hold_cycles = 300;
		random_mix(25);
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_hold_cycles > 0) begin
				out_stall <= 1'b1;
				stall_hold_cycles--;
			end else
				out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		flash_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (reply_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: drive_pins %h status %0d", drive_pins, status);
			end else begin
				want = reply_q.pop_front();
				replies_checked++;
				if (want.stat == sfr_pkg::STAT_UNKNOWN_CMD)
					unknown_seen++;
				if (want.stat == sfr_pkg::STAT_BEYOND_MEM)
					beyond_seen++;
				if (drive_pins !== want.drive || status !== want.stat) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d: drive_pins exp %h got %h, status exp %0d got %0d",
							replies_checked, want.drive, drive_pins, want.stat, status);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = 1'b0;
		clk_pin = 1'b0;
		select_n = 1'b1;
		data_in_pins = '0;
		load_address = '0;
		load_byte = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		flash_state = '0;
		flash_state.prev_sel_n = 1'b1;
		id_word_shadow = sfr_pkg::ID_WORD_RESET;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		test_idle_pins();
		test_accepted_commands();
		test_unknown_command();
		test_read_id();
		test_single_read();
		test_quad_read();
		test_memory_edges();
		test_deselect();
		test_random_traffic(15, 50, 25);
		test_random_traffic(50, 15, 25);
		test_random_traffic(0, 0, 25);
		test_stall_pressure();

		in_valid <= 1'b0;
		for (int n = 0; n < 2000 && reply_q.size() != 0; n++)
			@(posedge clk);
		repeat (5) @(posedge clk);
		if (reply_q.size() != 0)
			$display("%0d expected results never arrived", reply_q.size());
		mismatches += reply_q.size();

		$display("Covered %0d input transactions (%0d memory loads), %0d results checked.",
			items_sent, loads_sent, replies_checked);
		$display("Unknown command %0d, beyond memory %0d, id_word written %0d times.",
			unknown_seen, beyond_seen, id_writes);
		if (mismatches == 0)
			$display("spi_flash_responder_core test passed");
		else
			$display("spi_flash_responder_core test failed");
		$finish;
	end

endmodule

// ===== spi_flash_responder_core.f =====
hw/rtl/sfr_pkg.sv
hw/rtl/spi_flash_responder_core.sv
sim/spi_flash_responder_core_test.sv
